[design/draw_item_key_sorter_defines.svh]
// assertion macros for the draw item key sorter
`ifndef DRAW_ITEM_KEY_SORTER_DEFINES_SVH
`define DRAW_ITEM_KEY_SORTER_DEFINES_SVH

// check held at every clock edge outside reset
`define DIK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check held at every clock edge, reset included
`define DIK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/dik_pkg.sv]
// shared types and constants of the draw item key sorter
package dik_pkg;

  // width of every key field on the ports
  localparam int FIELD_W = 16;
  // width of the count fields on the ports
  localparam int CNT_W = 7;

  // control handed from the sequencer to every cell of the chain
  typedef struct packed {
    logic ins;     // place the new word into the chain
    logic drain;   // move every cell one place toward the head
    logic shadow;  // key order shader, mesh, material, primitive
  } chain_ctl_t;

endpackage

[design/dik_if.sv]
// valid/ready channels for draw items and sorted results
interface dik_in_if;
  logic                         valid;
  logic                         ready;
  logic [dik_pkg::FIELD_W-1:0]  shader_key;
  logic [dik_pkg::FIELD_W-1:0]  material_key;
  logic [dik_pkg::FIELD_W-1:0]  mesh_key;
  logic [dik_pkg::FIELD_W-1:0]  primitive_key;
  logic                         last_in;

  modport source (output valid, shader_key, material_key, mesh_key, primitive_key,
                  last_in, input ready);
  modport sink   (input valid, shader_key, material_key, mesh_key, primitive_key,
                  last_in, output ready);
endinterface

interface dik_out_if;
  logic                         valid;
  logic                         ready;
  logic [dik_pkg::FIELD_W-1:0]  out_shader;
  logic [dik_pkg::FIELD_W-1:0]  out_material;
  logic [dik_pkg::FIELD_W-1:0]  out_mesh;
  logic [dik_pkg::FIELD_W-1:0]  out_primitive;
  logic                         last_out;
  logic [dik_pkg::CNT_W-1:0]    draw_count;
  logic [dik_pkg::CNT_W-1:0]    shader_groups;
  logic [dik_pkg::CNT_W-1:0]    material_groups;
  logic [dik_pkg::CNT_W-1:0]    mesh_groups;
  logic                         overflow;

  modport source (output valid, out_shader, out_material, out_mesh, out_primitive,
                  last_out, draw_count, shader_groups, material_groups, mesh_groups,
                  overflow, input ready);
  modport sink   (input valid, out_shader, out_material, out_mesh, out_primitive,
                  last_out, draw_count, shader_groups, material_groups, mesh_groups,
                  overflow, output ready);
endinterface

[design/dik_cell.sv]
// one cell of the insertion chain: holds one draw item in sorted place
module dik_cell #(
  parameter int KW = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  dik_pkg::chain_ctl_t ctl,
  input  logic [4*KW-1:0]     new_item,
  input  logic [4*KW-1:0]     new_key,
  input  logic [4*KW-1:0]     prev_item,
  input  logic                prev_valid,
  input  logic                prev_gt,
  input  logic [4*KW-1:0]     next_item,
  input  logic                next_valid,
  output logic [4*KW-1:0]     item,
  output logic                valid,
  output logic                gt
);
  import dik_pkg::*;

  localparam int W = 4 * KW;

  logic [W-1:0] own_key;
  logic [W-1:0] item_next;
  logic         valid_next;

  // sort key of the held item: material and mesh swap in shadow order
  always_comb begin
    if (ctl.shadow) begin
      own_key = {item[4*KW-1:3*KW], item[2*KW-1:KW], item[3*KW-1:2*KW], item[KW-1:0]};
    end else begin
      own_key = item;
    end
  end

  // new word goes ahead of this one only on a strictly smaller key
  assign gt = valid && (new_key < own_key);

  // insert moves larger words one place away, drain moves all toward the head
  always_comb begin
    item_next  = item;
    valid_next = valid;
    if (ctl.drain) begin
      item_next  = next_item;
      valid_next = next_valid;
    end else if (ctl.ins) begin
      valid_next = valid || prev_valid;
      if (prev_gt) begin
        item_next = prev_item;
      end else if (gt || (!valid && prev_valid)) begin
        item_next = new_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[design/dik_chain.sv]
// row of insertion cells, smallest key at the head
module dik_chain #(
  parameter int DEPTH = 64,
  parameter int KW    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  dik_pkg::chain_ctl_t ctl,
  input  logic [4*KW-1:0]     new_item,
  output logic [4*KW-1:0]     head_item,
  output logic                head_valid
);
  import dik_pkg::*;

  localparam int W = 4 * KW;

  logic [W-1:0] item_a  [DEPTH];
  logic         valid_a [DEPTH];
  logic         gt_a    [DEPTH];
  logic [W-1:0] new_key;

  // sort key of the arriving word, shared by all cells
  always_comb begin
    if (ctl.shadow) begin
      new_key = {new_item[4*KW-1:3*KW], new_item[2*KW-1:KW], new_item[3*KW-1:2*KW],
                 new_item[KW-1:0]};
    end else begin
      new_key = new_item;
    end
  end

  // cells with neighbor links; the ends see an always-valid head and an empty tail
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] p_item;
    logic         p_valid;
    logic         p_gt;
    logic [W-1:0] n_item;
    logic         n_valid;

    if (i == 0) begin : g_head
      assign p_item  = '0;
      assign p_valid = 1'b1;
      assign p_gt    = 1'b0;
    end else begin : g_mid
      assign p_item  = item_a[i-1];
      assign p_valid = valid_a[i-1];
      assign p_gt    = gt_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_item  = '0;
      assign n_valid = 1'b0;
    end else begin : g_body
      assign n_item  = item_a[i+1];
      assign n_valid = valid_a[i+1];
    end

    dik_cell #(.KW(KW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_item   (new_item),
      .new_key    (new_key),
      .prev_item  (p_item),
      .prev_valid (p_valid),
      .prev_gt    (p_gt),
      .next_item  (n_item),
      .next_valid (n_valid),
      .item       (item_a[i]),
      .valid      (valid_a[i]),
      .gt         (gt_a[i])
    );
  end

  assign head_item  = item_a[0];
  assign head_valid = valid_a[0];

endmodule

[design/draw_item_key_sorter.sv]
// top level: draw items load one a cycle into a sorted insertion chain.
// after the last item is taken the drain flag is registered, then the first
// sorted word is loaded into the output register; then one word a cycle as taken.
// input is held off while the set's words drain, and output stalls draw that out.
// rst (sync, high) clears cell valid bits, counts and flags; no clear pass.
module draw_item_key_sorter #(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  dik_in_if.sink     din,
  dik_out_if.source  dout
);
  import dik_pkg::*;
  `include "draw_item_key_sorter_defines.svh"

  localparam int KW = KEY_WIDTH;
  localparam int W  = 4 * KW;
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic          shadow_mode;
  logic          draining;
  logic [CW-1:0] item_count;
  logic          overflow_flag;
  logic [CW-1:0] emit_idx;
  logic [CW-1:0] sh_g;
  logic [CW-1:0] mat_g;
  logic [CW-1:0] mesh_g;
  logic [KW-1:0] prev_sh;
  logic [KW-1:0] prev_mat;
  logic [KW-1:0] prev_mesh;

  logic          o_valid;
  logic [KW-1:0] o_sh;
  logic [KW-1:0] o_mat;
  logic [KW-1:0] o_mesh;
  logic [KW-1:0] o_prim;
  logic          o_last;
  logic [CW-1:0] o_count;
  logic [CW-1:0] o_sh_g;
  logic [CW-1:0] o_mat_g;
  logic [CW-1:0] o_mesh_g;
  logic          o_ovf;

  chain_ctl_t    ctl;
  logic [W-1:0]  new_item;
  logic [W-1:0]  head_item;
  logic          head_valid;
  logic          in_take;
  logic          full;
  logic          load;
  logic          final_word;
  logic          first_word;
  logic          sh_ch;
  logic          mat_ch;
  logic          mesh_ch;
  logic [KW-1:0] h_sh;
  logic [KW-1:0] h_mat;
  logic [KW-1:0] h_mesh;
  logic [CW-1:0] sh_g_next;
  logic [CW-1:0] mat_g_next;
  logic [CW-1:0] mesh_g_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_mode <= 1'b0;
    end else if (cfg_we) begin
      shadow_mode <= cfg_data;
    end
  end

  // input side: keep the low key bits, shader on top
  assign din.ready = !draining;
  assign in_take   = din.valid && din.ready;
  assign full      = (item_count == CW'(MAX_ITEMS));
  assign new_item  = {din.shader_key[KW-1:0], din.material_key[KW-1:0],
                      din.mesh_key[KW-1:0], din.primitive_key[KW-1:0]};

  // drain moves the head into the output register when it is free
  assign load       = draining && (!o_valid || dout.ready);
  assign final_word = (emit_idx == item_count - 1'b1);
  assign first_word = (emit_idx == '0);

  assign ctl.ins    = in_take && !full;
  assign ctl.drain  = load;
  assign ctl.shadow = shadow_mode;

  dik_chain #(.DEPTH(MAX_ITEMS), .KW(KW)) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .new_item   (new_item),
    .head_item  (head_item),
    .head_valid (head_valid)
  );

  // group changes against the previously emitted word
  assign h_sh        = head_item[4*KW-1:3*KW];
  assign h_mat       = head_item[3*KW-1:2*KW];
  assign h_mesh      = head_item[2*KW-1:KW];
  assign sh_ch       = first_word || (prev_sh != h_sh);
  assign mat_ch      = sh_ch || (prev_mat != h_mat);
  assign mesh_ch     = first_word || (prev_mesh != h_mesh);
  assign sh_g_next   = sh_g + CW'(sh_ch);
  assign mat_g_next  = mat_g + CW'(mat_ch);
  assign mesh_g_next = mesh_g + CW'(mesh_ch);

  // set sequencing: load, then drain, then clear for the next set
  always_ff @(posedge clk) begin
    if (rst) begin
      draining      <= 1'b0;
      item_count    <= '0;
      overflow_flag <= 1'b0;
      emit_idx      <= '0;
      sh_g          <= '0;
      mat_g         <= '0;
      mesh_g        <= '0;
    end else if (load) begin
      if (final_word) begin
        draining      <= 1'b0;
        item_count    <= '0;
        overflow_flag <= 1'b0;
        emit_idx      <= '0;
        sh_g          <= '0;
        mat_g         <= '0;
        mesh_g        <= '0;
      end else begin
        emit_idx <= emit_idx + 1'b1;
        sh_g     <= sh_g_next;
        mat_g    <= mat_g_next;
        mesh_g   <= mesh_g_next;
      end
    end else if (in_take) begin
      if (full) begin
        overflow_flag <= 1'b1;
      end else begin
        item_count <= item_count + 1'b1;
      end
      if (din.last_in) begin
        draining <= 1'b1;
      end
    end
  end

  // previous word keys
  always_ff @(posedge clk) begin
    if (load) begin
      prev_sh   <= h_sh;
      prev_mat  <= h_mat;
      prev_mesh <= h_mesh;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (dout.ready) begin
      o_valid <= 1'b0;
    end
  end

  // output register payload, counts only on the final word
  always_ff @(posedge clk) begin
    if (load) begin
      o_sh     <= h_sh;
      o_mat    <= h_mat;
      o_mesh   <= h_mesh;
      o_prim   <= head_item[KW-1:0];
      o_last   <= final_word;
      o_count  <= final_word ? item_count : '0;
      o_sh_g   <= final_word ? sh_g_next : '0;
      o_mat_g  <= final_word ? mat_g_next : '0;
      o_mesh_g <= final_word ? mesh_g_next : '0;
      o_ovf    <= final_word && overflow_flag;
    end
  end

  assign dout.valid           = o_valid;
  assign dout.out_shader      = FIELD_W'(o_sh);
  assign dout.out_material    = FIELD_W'(o_mat);
  assign dout.out_mesh        = FIELD_W'(o_mesh);
  assign dout.out_primitive   = FIELD_W'(o_prim);
  assign dout.last_out        = o_last;
  assign dout.draw_count      = CNT_W'(o_count);
  assign dout.shader_groups   = CNT_W'(o_sh_g);
  assign dout.material_groups = CNT_W'(o_mat_g);
  assign dout.mesh_groups     = CNT_W'(o_mesh_g);
  assign dout.overflow        = o_ovf;

  // a last item always starts the drain
  `DIK_ASSERT(a_last_starts_drain, (in_take && din.last_in) |=> draining, "no drain after last")
  // every held item sits in the chain, so a nonempty set has a valid head
  `DIK_ASSERT(a_head_held, (item_count != '0) |-> head_valid, "empty chain head")
  // drops only happen once the chain is full
  `DIK_ASSERT(a_ovf_full, (o_valid && o_ovf) |-> o_count == CW'(MAX_ITEMS), "early drop")

endmodule
